// ===== sv/sfed_pkg.sv =====
// Shared types, constants and arithmetic helpers for the stereo feedback echo delay.
// No dependencies; imported by sfed_lane and stereo_feedback_echo_delay.
package sfed_pkg;

  // Store geometry and sample format
  localparam int DEPTH    = 131072;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SAMPLE_W = 16;

  // Register widths
  localparam int MS_W       = 11;
  localparam int RATE_W     = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN     = 8'd3;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd48000;

  // Delay offset: rate * ms / 1000 by reciprocal multiply, exact for PROD_W-bit products
  localparam int PROD_W                  = RATE_W + MS_W;
  localparam int OFF_SHIFT               = PROD_W + 10;
  localparam longint unsigned OFF_RECIP_L = ((64'd1 << OFF_SHIFT) + 64'd999) / 64'd1000;
  localparam int OFF_RECIP_W             = $clog2(OFF_RECIP_L + 64'd1);
  localparam logic [OFF_RECIP_W-1:0] OFF_RECIP = OFF_RECIP_W'(OFF_RECIP_L);
  localparam int Q_W                     = PROD_W - 9;

  // Gain products: sample times percent, then / 100 toward zero
  localparam int PG_W                       = SAMPLE_W + PCT_W;
  localparam int SUM_W                      = PG_W + 1;
  localparam int DIV_SHIFT                  = PG_W + 6;
  localparam longint unsigned DIV_RECIP_L   = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
  localparam logic [PG_W-1:0] DIV_RECIP     = PG_W'(DIV_RECIP_L);

  localparam logic signed [SUM_W-1:0] S_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] S_LO = -S_HI - SUM_W'(1);

  // Per-item controls from the sequencer to each lane
  typedef struct packed {
    logic              load;
    logic              rd;
    logic              gain;
    logic              sum;
    logic              mul_fb;
    logic              wr;
    logic              use_s0;
    logic              hit;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
  } lane_ctl_t;

  // Signed divide by 100, truncating toward zero (magnitude times reciprocal)
  function automatic logic signed [PG_W-1:0] div100(input logic signed [PG_W-1:0] v);
    logic [PG_W-1:0]   mag;
    logic [2*PG_W-1:0] prod;
    logic [PG_W-1:0]   q;
    mag  = v[PG_W-1] ? PG_W'(-v) : PG_W'(v);
    prod = (2*PG_W)'(mag) * (2*PG_W)'(DIV_RECIP);
    q    = PG_W'(prod >> DIV_SHIFT);
    return v[PG_W-1] ? -$signed(q) : $signed(q);
  endfunction

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > S_HI) begin
      c = S_HI;
    end else if (v < S_LO) begin
      c = S_LO;
    end else begin
      c = v;
    end
    return SAMPLE_W'(c);
  endfunction

endpackage

// ===== sv/sfed_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sfed_lane.sv =====
// One channel lane: delay store, input gain, echo sum and feedback write-back.
// Depends on sfed_pkg and sfed_ram.
module sfed_lane
  import sfed_pkg::*;
(
  input  logic                       clk,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] x_i,
  input  logic [PCT_W-1:0]           in_gain_i,
  input  logic [PCT_W-1:0]           fb_gain_i,
  output logic signed [SAMPLE_W-1:0] y_o
);

  logic signed [SAMPLE_W-1:0] x_r, s0_r, s0_nxt, y_r, y_nxt, delayed;
  logic signed [PG_W-1:0]     pin_r, pin_nxt, pfb_r, pfb_nxt;
  logic [SAMPLE_W-1:0]        rdata, wdata;

  sfed_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ctl.wr),
    .waddr(ctl.wr_addr),
    .wdata(wdata),
    .re   (ctl.rd),
    .raddr(ctl.rd_addr),
    .rdata(rdata)
  );

  // dry sample times input gain
  assign pin_nxt = PG_W'(x_r) * PG_W'($signed({1'b0, in_gain_i}));
  // stored dry part
  assign s0_nxt  = sat_sample(SUM_W'(div100(pin_r)));

  // zero delay uses this item's stored dry part; unwritten entries read as zero
  always_comb begin
    if (ctl.use_s0) begin
      delayed = s0_r;
    end else if (ctl.hit) begin
      delayed = $signed(rdata);
    end else begin
      delayed = '0;
    end
  end

  assign y_nxt   = sat_sample(SUM_W'(x_r) + SUM_W'(delayed));
  assign pfb_nxt = PG_W'(y_r) * PG_W'($signed({1'b0, fb_gain_i}));
  assign wdata   = sat_sample(SUM_W'(s0_r) + SUM_W'(div100(pfb_r)));

  // datapath registers, one enable per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= x_i;
    end
    if (ctl.rd) begin
      pin_r <= pin_nxt;
    end
    if (ctl.gain) begin
      s0_r <= s0_nxt;
    end
    if (ctl.sum) begin
      y_r <= y_nxt;
    end
    if (ctl.mul_fb) begin
      pfb_r <= pfb_nxt;
    end
  end

  assign y_o = y_r;

endmodule

// ===== sv/stereo_feedback_echo_delay.sv =====
// Stereo feedback echo delay: one sample pair per item, two lanes sharing a write position.
// Accepted items run the step sequencer (read, gain, sum, feedback multiply, write-back),
// which waits at write-back while out_valid is high and out_ready low; a new item is taken
// only in idle; a register write holds the input off while the delay offset settles.
// Reset (rst_n low, synchronous): registers to defaults, write position 0; the stores are
// not swept: a wrap flag and the write position mark unwritten entries, which read as zero.
module stereo_feedback_echo_delay
  import sfed_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_in,
  input  logic signed [SAMPLE_W-1:0] in_right_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_GAIN  = 6'b000100,
    S_SUM   = 6'b001000,
    S_FB    = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [MS_W-1:0]            ms_r;
  logic [RATE_W-1:0]          rate_r;
  logic [PCT_W-1:0]           ig_r, fb_r;
  logic                       cfg_busy_r;
  logic [PROD_W-1:0]          prod_r;
  logic [PROD_W+OFF_RECIP_W-1:0] qprod;
  logic [Q_W-1:0]             q;
  logic [ADDR_W-1:0]          off_r, off_nxt;
  logic [ADDR_W-1:0]          w_r, w_nxt, rd_addr;
  logic [ADDR_W:0]            rd_wrap;
  logic                       wrapped_r, use_s0_r, hit_r;
  logic                       out_valid_r, done;
  logic signed [SAMPLE_W-1:0] out_l_r, out_r_r, y_l, y_r_lane;
  lane_ctl_t                  ctl;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r   <= '0;
      rate_r <= RATE_RESET;
      ig_r   <= '0;
      fb_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY_MS:    ms_r   <= cfg_data[MS_W-1:0];
        REG_SAMPLE_RATE: rate_r <= cfg_data[RATE_W-1:0];
        REG_INPUT_GAIN:  ig_r   <= cfg_data[PCT_W-1:0];
        REG_FB_GAIN:     fb_r   <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // busy flag registered from each register write; holds the input off while the offset updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_busy_r <= 1'b0;
    end else begin
      cfg_busy_r <= cfg_valid && cfg_ready;
    end
  end

  // delay offset in samples, recomputed every cycle from the registers
  assign qprod = (PROD_W+OFF_RECIP_W)'(prod_r) * (PROD_W+OFF_RECIP_W)'(OFF_RECIP);
  assign q     = Q_W'(qprod >> OFF_SHIFT);

  always_comb begin
    if (32'(q) > 32'(DEPTH - 1)) begin
      off_nxt = ADDR_W'(DEPTH - 1);
    end else begin
      off_nxt = ADDR_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
      off_r  <= '0;
    end else begin
      prod_r <= PROD_W'(rate_r) * PROD_W'(ms_r);
      off_r  <= off_nxt;
    end
  end

  // read address: write position minus offset, modulo depth
  assign rd_wrap = {1'b0, w_r} + (ADDR_W+1)'(DEPTH) - {1'b0, off_r};
  always_comb begin
    if (w_r >= off_r) begin
      rd_addr = w_r - off_r;
    end else begin
      rd_addr = ADDR_W'(rd_wrap);
    end
  end

  assign w_nxt = (w_r == ADDR_W'(DEPTH - 1)) ? '0 : w_r + ADDR_W'(1);

  // step sequencer
  assign done = (state_r == S_WRITE) && (!out_valid_r || out_ready);

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = (in_valid && in_ready) ? S_READ : S_IDLE;
      S_READ:  state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_FB;
      S_FB:    state_nxt = S_WRITE;
      S_WRITE: state_nxt = done ? S_IDLE : S_WRITE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      w_r       <= '0;
      wrapped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        w_r <= w_nxt;
        if (w_r == ADDR_W'(DEPTH - 1)) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  // delayed-sample source, fixed at the read step
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      use_s0_r <= (off_r == '0);
      hit_r    <= wrapped_r || (rd_addr < w_r);
    end
  end

  assign in_ready = (state_r == S_IDLE) && !cfg_busy_r;

  always_comb begin
    ctl.load    = in_valid && in_ready;
    ctl.rd      = (state_r == S_READ);
    ctl.gain    = (state_r == S_GAIN);
    ctl.sum     = (state_r == S_SUM);
    ctl.mul_fb  = (state_r == S_FB);
    ctl.wr      = done;
    ctl.use_s0  = use_s0_r;
    ctl.hit     = hit_r;
    ctl.rd_addr = rd_addr;
    ctl.wr_addr = w_r;
  end

  sfed_lane u_left (
    .clk      (clk),
    .ctl      (ctl),
    .x_i      (in_left_in),
    .in_gain_i(ig_r),
    .fb_gain_i(fb_r),
    .y_o      (y_l)
  );

  sfed_lane u_right (
    .clk      (clk),
    .ctl      (ctl),
    .x_i      (in_right_in),
    .in_gain_i(ig_r),
    .fb_gain_i(fb_r),
    .y_o      (y_r_lane)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_l_r <= y_l;
      out_r_r <= y_r_lane;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

endmodule
